@@ src/hdrtm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrtm_pkg
// Shared types and constants of the HDR tone mapper.
// ----------------------------------------------------------------------------
package hdrtm_pkg;

   localparam int CH_W           = 24;
   localparam int DEF_FRAC_BITS  = 16;

   // Luminance weights scaled by LUM_K
   localparam int LUM_K = 10000;
   localparam int LUM_R = 2126;
   localparam int LUM_G = 7152;
   localparam int LUM_B = 722;
   localparam int LK_W  = 14;   // bits of LUM_K
   localparam int LS_W  = 38;   // bits of the scaled luminance sum

   typedef enum logic [1:0] {
      MODE_CLAMP,
      MODE_REINHARD,
      MODE_EXT_CH,
      MODE_EXT_LUM
   } mode_type;

   typedef enum logic {
      CSR_MODE,
      CSR_WHITE
   } csr_index_type;

   localparam mode_type         MODE_RST  = MODE_REINHARD;
   localparam logic [CH_W-1:0]  WHITE_RST = 24'd65536;

endpackage

@@ src/hdrtm_prep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrtm_prep
// Six stage front end: builds the exact numerator and denominator of each
// channel's quotient from the pixel, the mode and the white point.
// ----------------------------------------------------------------------------
module hdrtm_prep
   import hdrtm_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS,
   parameter int NUM_W     = 1,
   parameter int DEN_W     = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [CH_W-1:0]  chan    [3],
   input  mode_type         mode,
   input  logic [CH_W-1:0]  white,
   output logic             out_valid,
   output logic [NUM_W-1:0] num     [3],
   output logic [DEN_W-1:0] den     [3]
);

   localparam int D_W    = ((LS_W > LK_W + FRAC_BITS) ? LS_W : LK_W + FRAC_BITS) + 1;
   localparam int KW2_W  = LK_W + 2 * CH_W;
   localparam int LSS_W  = LS_W + FRAC_BITS;
   localparam int X_W    = ((KW2_W > LSS_W) ? KW2_W : LSS_W) + 1;
   localparam int XL     = (X_W + 1) / 2;
   localparam int XH     = X_W - XL;
   localparam int DL     = (D_W + 1) / 2;
   localparam int DH     = D_W - DL;
   localparam int WD_W   = CH_W + D_W;
   localparam int WL     = (WD_W + 1) / 2;
   localparam int WH     = WD_W - WL;
   localparam int CX_W   = CH_W + X_W;
   localparam logic [D_W-1:0] S_D  = D_W'(1) << FRAC_BITS;
   localparam logic [D_W-1:0] KS_D = D_W'(LUM_K) << FRAC_BITS;

   // white point derived terms, registered in w2_ff and then kw2_ff after a write
   logic [CH_W-1:0]    w_eff;
   logic [2*CH_W-1:0]  w2_ff;
   logic [KW2_W-1:0]   kw2_ff;

   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   mode_type           mode1_ff, mode2_ff;
   logic [CH_W-1:0]    c1_ff [3];
   logic [CH_W-1:0]    c2_ff [3];
   logic [CH_W-1:0]    c3_ff [3];
   logic [LS_W-1:0]    ls2_ff, ls_in;
   logic [D_W-1:0]     d2_ff [3];
   logic [D_W-1:0]     d_in  [3];
   logic [X_W-1:0]     x3_ff [3];
   logic [X_W-1:0]     x_in  [3];
   logic [CH_W+DL-1:0] pdl3_ff [3];
   logic [CH_W+DL-1:0] pdl_in  [3];
   logic [CH_W+DH-1:0] pdh3_ff [3];
   logic [CH_W+DH-1:0] pdh_in  [3];
   logic [CH_W-1:0]    wsel_in, wsel3_ff, wsel4_ff;
   logic [CH_W+XL-1:0] pxl4_ff [3];
   logic [CH_W+XL-1:0] pxl_in  [3];
   logic [CH_W+XH-1:0] pxh4_ff [3];
   logic [CH_W+XH-1:0] pxh_in  [3];
   logic [WD_W-1:0]    wd4_ff  [3];
   logic [WD_W-1:0]    wd_in   [3];
   logic [NUM_W-1:0]   num5_ff [3];
   logic [NUM_W-1:0]   num6_ff [3];
   logic [NUM_W-1:0]   num_in  [3];
   logic [CH_W+WL-1:0] qdl5_ff [3];
   logic [CH_W+WL-1:0] qdl_in  [3];
   logic [CH_W+WH-1:0] qdh5_ff [3];
   logic [CH_W+WH-1:0] qdh_in  [3];
   logic [DEN_W-1:0]   den6_ff [3];
   logic [DEN_W-1:0]   den_in  [3];

   assign w_eff = (white == '0) ? CH_W'(1) : white;

   always_ff @(posedge clock) begin
      w2_ff  <= (2*CH_W)'(w_eff) * (2*CH_W)'(w_eff);
      kw2_ff <= KW2_W'(LUM_K) * KW2_W'(w2_ff);
   end

   // stage 2: luminance and the per channel rate term
   always_comb begin
      ls_in = LS_W'(LUM_R) * LS_W'(c1_ff[0]) + LS_W'(LUM_G) * LS_W'(c1_ff[1])
            + LS_W'(LUM_B) * LS_W'(c1_ff[2]);
      for (int ch = 0; ch < 3; ch++) begin
         case (mode1_ff)
            MODE_CLAMP:    d_in[ch] = (D_W'(c1_ff[ch]) >= S_D) ? D_W'(c1_ff[ch]) : S_D;
            MODE_REINHARD,
            MODE_EXT_CH:   d_in[ch] = S_D + D_W'(c1_ff[ch]);
            MODE_EXT_LUM:  d_in[ch] = KS_D + D_W'(ls_in);
            default:       d_in[ch] = S_D;
         endcase
      end
   end

   // stage 3: numerator factor, first half of the denominator product
   always_comb begin
      wsel_in = (mode2_ff == MODE_CLAMP || mode2_ff == MODE_REINHARD) ? CH_W'(1) : w_eff;
      for (int ch = 0; ch < 3; ch++) begin
         case (mode2_ff)
            MODE_EXT_CH:  x_in[ch] = X_W'(w2_ff) + (X_W'(c2_ff[ch]) << FRAC_BITS);
            MODE_EXT_LUM: x_in[ch] = X_W'(kw2_ff) + (X_W'(ls2_ff) << FRAC_BITS);
            default:      x_in[ch] = X_W'(1);
         endcase
         pdl_in[ch] = (CH_W+DL)'(wsel_in) * (CH_W+DL)'(d2_ff[ch][DL-1:0]);
         pdh_in[ch] = (CH_W+DH)'(wsel_in) * (CH_W+DH)'(d2_ff[ch][D_W-1:DL]);
      end
   end

   // stages 4 to 6: partial products and their sums
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         pxl_in[ch] = (CH_W+XL)'(c3_ff[ch]) * (CH_W+XL)'(x3_ff[ch][XL-1:0]);
         pxh_in[ch] = (CH_W+XH)'(c3_ff[ch]) * (CH_W+XH)'(x3_ff[ch][X_W-1:XL]);
         wd_in[ch]  = WD_W'(pdl3_ff[ch]) + (WD_W'(pdh3_ff[ch]) << DL);
         num_in[ch] = NUM_W'(CX_W'(pxl4_ff[ch]) + (CX_W'(pxh4_ff[ch]) << XL)) << FRAC_BITS;
         qdl_in[ch] = (CH_W+WL)'(wsel4_ff) * (CH_W+WL)'(wd4_ff[ch][WL-1:0]);
         qdh_in[ch] = (CH_W+WH)'(wsel4_ff) * (CH_W+WH)'(wd4_ff[ch][WD_W-1:WL]);
         den_in[ch] = DEN_W'(qdl5_ff[ch]) + (DEN_W'(qdh5_ff[ch]) << WL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode1_ff <= mode;
         mode2_ff <= mode1_ff;
         ls2_ff   <= ls_in;
         wsel3_ff <= wsel_in;
         wsel4_ff <= wsel3_ff;
         for (int ch = 0; ch < 3; ch++) begin
            c1_ff[ch]   <= chan[ch];
            c2_ff[ch]   <= c1_ff[ch];
            c3_ff[ch]   <= c2_ff[ch];
            d2_ff[ch]   <= d_in[ch];
            x3_ff[ch]   <= x_in[ch];
            pdl3_ff[ch] <= pdl_in[ch];
            pdh3_ff[ch] <= pdh_in[ch];
            pxl4_ff[ch] <= pxl_in[ch];
            pxh4_ff[ch] <= pxh_in[ch];
            wd4_ff[ch]  <= wd_in[ch];
            num5_ff[ch] <= num_in[ch];
            qdl5_ff[ch] <= qdl_in[ch];
            qdh5_ff[ch] <= qdh_in[ch];
            num6_ff[ch] <= num5_ff[ch];
            den6_ff[ch] <= den_in[ch];
         end
      end
   end

   assign out_valid = v6_ff;
   assign num       = num6_ff;
   assign den       = den6_ff;

endmodule

@@ src/hdrtm_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrtm_divider
// Pipelined restoring divider for three channels: an overflow check stage,
// then one quotient bit per stage. Quotients above full scale saturate.
// ----------------------------------------------------------------------------
module hdrtm_divider
   import hdrtm_pkg::*;
#(
   parameter int NUM_W = 1,
   parameter int DEN_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] num [3],
   input  logic [DEN_W-1:0] den [3],
   output logic             out_valid,
   output logic [CH_W-1:0]  quot [3],
   output logic             saturated
);

   localparam int R_W   = DEN_W + 1;
   localparam int CMP_W = (NUM_W > DEN_W + CH_W) ? NUM_W : DEN_W + CH_W;

   logic             v_ff    [CH_W+1];
   logic             v_in    [CH_W+1];
   logic [R_W-1:0]   rem_ff  [CH_W+1][3];
   logic [R_W-1:0]   rem_in  [CH_W+1][3];
   logic [CH_W-1:0]  low_ff  [CH_W+1][3];
   logic [CH_W-1:0]  low_in  [CH_W+1][3];
   logic [CH_W-1:0]  q_ff    [CH_W+1][3];
   logic [CH_W-1:0]  q_in    [CH_W+1][3];
   logic [DEN_W-1:0] den_ff  [CH_W+1][3];
   logic [DEN_W-1:0] den_in  [CH_W+1][3];
   logic             ovf_ff  [CH_W+1][3];
   logic             ovf_in  [CH_W+1][3];
   logic [R_W-1:0]   trial   [CH_W+1][3];

   always_comb begin
      v_in[0] = in_valid;
      for (int ch = 0; ch < 3; ch++) begin
         // quotient reaches 2^24 exactly when num >= den * 2^24
         ovf_in[0][ch] = CMP_W'(num[ch]) >= (CMP_W'(den[ch]) << CH_W);
         rem_in[0][ch] = R_W'(num[ch] >> CH_W);
         low_in[0][ch] = num[ch][CH_W-1:0];
         q_in[0][ch]   = '0;
         den_in[0][ch] = den[ch];
         trial[0][ch]  = '0;
      end
      for (int k = 1; k <= CH_W; k++) begin
         v_in[k] = v_ff[k-1];
         for (int ch = 0; ch < 3; ch++) begin
            trial[k][ch]  = {rem_ff[k-1][ch][R_W-2:0], low_ff[k-1][ch][CH_W-1]};
            low_in[k][ch] = low_ff[k-1][ch] << 1;
            den_in[k][ch] = den_ff[k-1][ch];
            ovf_in[k][ch] = ovf_ff[k-1][ch];
            if (trial[k][ch] >= R_W'(den_ff[k-1][ch])) begin
               rem_in[k][ch] = trial[k][ch] - R_W'(den_ff[k-1][ch]);
               q_in[k][ch]   = {q_ff[k-1][ch][CH_W-2:0], 1'b1};
            end else begin
               rem_in[k][ch] = trial[k][ch];
               q_in[k][ch]   = {q_ff[k-1][ch][CH_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= CH_W; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k <= CH_W; k++) begin
            v_ff[k] <= v_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= CH_W; k++) begin
            for (int ch = 0; ch < 3; ch++) begin
               rem_ff[k][ch] <= rem_in[k][ch];
               low_ff[k][ch] <= low_in[k][ch];
               q_ff[k][ch]   <= q_in[k][ch];
               den_ff[k][ch] <= den_in[k][ch];
               ovf_ff[k][ch] <= ovf_in[k][ch];
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         quot[ch] = ovf_ff[CH_W][ch] ? '1 : q_ff[CH_W][ch];
      end
   end

   assign saturated = ovf_ff[CH_W][0] | ovf_ff[CH_W][1] | ovf_ff[CH_W][2];
   assign out_valid = v_ff[CH_W];

endmodule

@@ src/hdr_tone_mapper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_tone_mapper
// Reinhard family tone mapper for unsigned fixed point RGB pixels.
// ----------------------------------------------------------------------------
// One pixel per clock while the output is not stalled: six stages build
// each channel's exact numerator and denominator (multiplies split the
// wide operand into halves), one stage checks for overflow and 24 stages
// of a restoring divider produce one quotient bit each. The whole pipe holds
// while a result is waiting on rsp_ready. The user writes mode and white point
// through the csr port between transactions; the block does not enforce it.
// ----------------------------------------------------------------------------
module hdr_tone_mapper
   import hdrtm_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [CH_W-1:0] req_red_in,
   input  logic [CH_W-1:0] req_green_in,
   input  logic [CH_W-1:0] req_blue_in,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [CH_W-1:0] rsp_red_out,
   output logic [CH_W-1:0] rsp_green_out,
   output logic [CH_W-1:0] rsp_blue_out,
   output logic            rsp_saturated,
   input  logic            csr_wen,
   input  logic            csr_index,
   input  logic [CH_W-1:0] csr_wdata
);

   localparam int D_W    = ((LS_W > LK_W + FRAC_BITS) ? LS_W : LK_W + FRAC_BITS) + 1;
   localparam int KW2_W  = LK_W + 2 * CH_W;
   localparam int LSS_W  = LS_W + FRAC_BITS;
   localparam int X_W    = ((KW2_W > LSS_W) ? KW2_W : LSS_W) + 1;
   localparam int NUM_W  = CH_W + X_W + FRAC_BITS;
   localparam int DEN_W  = 2 * CH_W + D_W;

   mode_type         mode_ff;
   logic [CH_W-1:0]  white_ff;
   logic             en;
   logic [CH_W-1:0]  chan [3];
   logic             mid_valid;
   logic [NUM_W-1:0] num  [3];
   logic [DEN_W-1:0] den  [3];
   logic [CH_W-1:0]  quot [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_RST;
         white_ff <= WHITE_RST;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:  mode_ff  <= mode_type'(csr_wdata[1:0]);
            CSR_WHITE: white_ff <= csr_wdata;
            default:   mode_ff  <= mode_ff;
         endcase
      end
   end

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   assign chan[0] = req_red_in;
   assign chan[1] = req_green_in;
   assign chan[2] = req_blue_in;

   hdrtm_prep #(
      .FRAC_BITS (FRAC_BITS),
      .NUM_W     (NUM_W),
      .DEN_W     (DEN_W)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .chan      (chan),
      .mode      (mode_ff),
      .white     (white_ff),
      .out_valid (mid_valid),
      .num       (num),
      .den       (den)
   );

   hdrtm_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mid_valid),
      .num       (num),
      .den       (den),
      .out_valid (rsp_valid),
      .quot      (quot),
      .saturated (rsp_saturated)
   );

   assign rsp_red_out   = quot[0];
   assign rsp_green_out = quot[1];
   assign rsp_blue_out  = quot[2];

endmodule
